[hw/rtl/pfa_pkg.sv]
// Package: shared types, opcodes and field constants for the prime field ALU
`default_nettype none
package pfa_pkg;
  localparam int unsigned OpW = 4;
  localparam logic [OpW-1:0] OP_ADD   = 4'd0;
  localparam logic [OpW-1:0] OP_SUB   = 4'd1;
  localparam logic [OpW-1:0] OP_MUL   = 4'd2;
  localparam logic [OpW-1:0] OP_SQR   = 4'd3;
  localparam logic [OpW-1:0] OP_DIV   = 4'd4;
  localparam logic [OpW-1:0] OP_INV   = 4'd5;
  localparam logic [OpW-1:0] OP_POW   = 4'd6;
  localparam logic [OpW-1:0] OP_CHI   = 4'd7;
  localparam logic [OpW-1:0] OP_SQRT  = 4'd8;
  localparam logic [OpW-1:0] OP_GTH   = 4'd9;

  localparam logic [255:0] Q      = {5'd0, {247{1'b1}}, 4'h7};
  localparam logic [255:0] E_QM2  = {5'd0, {247{1'b1}}, 4'h5};
  localparam logic [255:0] E_HALF = {6'd0, {247{1'b1}}, 3'h3};
  localparam logic [255:0] E_QUART = {7'd0, {247{1'b1}}, 2'h2};
  // 64*q = 2^257 - 576, added before a subtraction so the difference stays positive
  localparam logic [264:0] Q_X64  = {3'd0, Q, 6'd0};

  // datapath commands from the controller
  localparam logic [2:0] DP_NOP    = 3'd0;
  localparam logic [2:0] DP_LOAD   = 3'd1; // latch operands, acc=1
  localparam logic [2:0] DP_ADDSUB = 3'd2; // fold = a + b or a + 64q - b
  localparam logic [2:0] DP_MUL    = 3'd3; // one 32x32 partial product of x*y
  localparam logic [2:0] DP_RED    = 3'd4; // one fold step at bit 251
  localparam logic [2:0] DP_FIN    = 3'd5; // final subtract, write acc
  localparam logic [2:0] DP_GTH    = 3'd6; // compare a, clear acc
  localparam logic [2:0] DP_PFOLD  = 3'd7; // first fold of the product: 2^256 = 288

  // multiplier operand selects
  localparam logic [1:0] SEL_ACC = 2'd0;
  localparam logic [1:0] SEL_A   = 2'd1;
  localparam logic [1:0] SEL_B   = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] msel_x;
    logic [1:0] msel_y;
    logic       sub;
  } pfa_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic red_done;
    logic acc_one;
    logic gth;
  } pfa_stat_t;
endpackage
`default_nettype wire

[hw/rtl/pfa_if.sv]
// Interface: valid/ready channel carrying a generic payload
`default_nettype none
interface pfa_if #(parameter int unsigned W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/pfa_datapath.sv]
// Datapath: operand registers, 32x32 limb multiplier and pseudo-Mersenne folding
`default_nettype none
module pfa_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfa_pkg::pfa_cmd_t cmd,
  output pfa_pkg::pfa_stat_t     stat,
  input  wire logic [255:0]      a_in,
  input  wire logic [255:0]      b_in,
  output logic [250:0]           res
);
  logic [255:0] a_reg, b_reg, acc;
  logic         gth;
  logic [255:0] x_op, y_op;
  logic [31:0]  xw, yw;
  logic [63:0]  pp;
  logic [3:0]   pp_pos;
  logic [511:0] pp_sh;
  logic [511:0] prod;
  logic [5:0]   mcnt;
  logic [264:0] fold;
  logic [264:0] fold_next;
  logic [264:0] fold_prod;
  logic [264:0] fold_sum;
  logic [264:0] fold_diff;
  logic [255:0] fin_d;
  logic         fin_ge;

  // select multiplier operands
  always_comb begin
    case (cmd.msel_x)
      pfa_pkg::SEL_A: x_op = a_reg;
      pfa_pkg::SEL_B: x_op = b_reg;
      default:        x_op = acc;
    endcase
    case (cmd.msel_y)
      pfa_pkg::SEL_A: y_op = a_reg;
      pfa_pkg::SEL_B: y_op = b_reg;
      default:        y_op = acc;
    endcase
  end

  // one 32x32 partial product per cycle, schoolbook over 64 steps
  assign xw = x_op[{mcnt[5:3], 5'd0} +: 32];
  assign yw = y_op[{mcnt[2:0], 5'd0} +: 32];
  assign pp = 64'(xw) * 64'(yw);
  assign pp_pos = 4'(mcnt[5:3]) + 4'(mcnt[2:0]);
  assign pp_sh = {448'd0, pp} << {pp_pos, 5'd0};

  // fold the product at bit 256 (times 288), then at bit 251 (times 9)
  assign fold_prod = 265'({prod[511:256], 8'd0}) + 265'({prod[511:256], 5'd0}) +
                     265'(prod[255:0]);
  assign fold_next = 265'(fold[250:0]) + 265'({fold[264:251], 3'd0}) +
                     265'(fold[264:251]);
  assign fold_sum  = 265'(a_reg) + 265'(b_reg);
  assign fold_diff = 265'(a_reg) + pfa_pkg::Q_X64 - 265'(b_reg);

  // final conditional subtract of q
  assign fin_ge = (fold >= 265'(pfa_pkg::Q));
  assign fin_d  = 256'(fold - 265'(pfa_pkg::Q));

  assign stat.mul_done = (mcnt == 6'd63);
  assign stat.red_done = (fold[264:251] == 14'd0);
  assign stat.acc_one  = (acc == 256'd1);
  assign stat.gth      = gth;
  assign res = acc[250:0];

  // advance the partial product counter while multiplying
  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= 6'd0;
    end else if (cmd.cmd == pfa_pkg::DP_MUL) begin
      mcnt <= mcnt + 6'd1;
    end else begin
      mcnt <= 6'd0;
    end
  end

  // execute the controller command
  always_ff @(posedge clk) begin
    case (cmd.cmd)
      pfa_pkg::DP_LOAD: begin
        a_reg <= a_in;
        b_reg <= b_in;
        acc   <= 256'd1;
        gth   <= 1'b0;
      end
      pfa_pkg::DP_ADDSUB: begin
        fold <= cmd.sub ? fold_diff : fold_sum;
      end
      pfa_pkg::DP_MUL: begin
        prod <= (mcnt == 6'd0) ? pp_sh : prod + pp_sh;
      end
      pfa_pkg::DP_PFOLD: begin
        fold <= fold_prod;
      end
      pfa_pkg::DP_RED: begin
        fold <= fold_next;
      end
      pfa_pkg::DP_FIN: begin
        acc <= fin_ge ? fin_d : fold[255:0];
      end
      pfa_pkg::DP_GTH: begin
        gth <= (a_reg > pfa_pkg::E_HALF);
        acc <= 256'd0;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/pfa_ctrl.sv]
// Controller: sequences reductions, multiplies and square-and-multiply ladders
`default_nettype none
module pfa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         op_in,
  input  wire logic [255:0]       b_raw,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    flag_out,
  input  wire pfa_pkg::pfa_stat_t stat,
  output pfa_pkg::pfa_cmd_t       cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ASUB = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RED0 = 3'd3;
  localparam logic [2:0] S_RED  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_GTH  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]   state;
  logic [3:0]   op;
  logic [255:0] exps;
  logic [7:0]   k;
  logic         phase_mul;  // 0 squaring, 1 multiply by base
  logic         pass2;      // div: final a*t
  logic [1:0]   mx, my;
  logic         ebit;
  logic         is_pow;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign ebit = exps[k];

  assign is_pow = (op == pfa_pkg::OP_DIV) || (op == pfa_pkg::OP_INV) ||
                  (op == pfa_pkg::OP_POW) || (op == pfa_pkg::OP_CHI) ||
                  (op == pfa_pkg::OP_SQRT);

  // chi reports anything but one; gt_half reports the compare
  assign flag_out = (op == pfa_pkg::OP_CHI) ? !stat.acc_one :
                    (op == pfa_pkg::OP_GTH) ? stat.gth : 1'b0;

  // decode state into a datapath command; load on the accepting edge
  always_comb begin
    cmd = '0;
    cmd.msel_x = mx;
    cmd.msel_y = my;
    case (state)
      S_IDLE: cmd.cmd = in_valid ? pfa_pkg::DP_LOAD : pfa_pkg::DP_NOP;
      S_ASUB: begin
        cmd.cmd = pfa_pkg::DP_ADDSUB;
        cmd.sub = (op == pfa_pkg::OP_SUB);
      end
      S_MUL:  cmd.cmd = pfa_pkg::DP_MUL;
      S_RED0: cmd.cmd = pfa_pkg::DP_PFOLD;
      S_RED:  cmd.cmd = pfa_pkg::DP_RED;
      S_FIN:  cmd.cmd = pfa_pkg::DP_FIN;
      S_GTH:  cmd.cmd = pfa_pkg::DP_GTH;
      default: cmd.cmd = pfa_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        // take a transfer, pick the exponent and the first step
        S_IDLE: if (in_valid) begin
          op        <= op_in;
          pass2     <= 1'b0;
          phase_mul <= 1'b0;
          k         <= 8'd255;
          case (op_in)
            pfa_pkg::OP_INV, pfa_pkg::OP_DIV: exps <= pfa_pkg::E_QM2;
            pfa_pkg::OP_CHI:  exps <= pfa_pkg::E_HALF;
            pfa_pkg::OP_SQRT: exps <= pfa_pkg::E_QUART;
            default:          exps <= b_raw;
          endcase
          case (op_in)
            pfa_pkg::OP_ADD, pfa_pkg::OP_SUB: state <= S_ASUB;
            pfa_pkg::OP_MUL: begin
              mx <= pfa_pkg::SEL_A; my <= pfa_pkg::SEL_B; state <= S_MUL;
            end
            pfa_pkg::OP_SQR: begin
              mx <= pfa_pkg::SEL_A; my <= pfa_pkg::SEL_A; state <= S_MUL;
            end
            pfa_pkg::OP_DIV, pfa_pkg::OP_INV, pfa_pkg::OP_POW, pfa_pkg::OP_CHI,
            pfa_pkg::OP_SQRT: begin
              mx <= pfa_pkg::SEL_ACC; my <= pfa_pkg::SEL_ACC; state <= S_MUL;
            end
            default: state <= S_GTH;
          endcase
        end
        S_ASUB: state <= S_RED;
        S_MUL: if (stat.mul_done) state <= S_RED0;
        S_RED0: state <= S_RED;
        S_RED: if (stat.red_done) state <= S_FIN;
        // ladder: multiply on a set bit, else square the next bit; div then a*t; then done
        S_FIN: begin
          state <= S_DONE;
          if (is_pow && !pass2) begin
            if (!phase_mul && ebit) begin
              phase_mul <= 1'b1;
              mx <= pfa_pkg::SEL_ACC;
              my <= (op == pfa_pkg::OP_DIV) ? pfa_pkg::SEL_B : pfa_pkg::SEL_A;
              state <= S_MUL;
            end else if (k != 8'd0) begin
              k <= k - 8'd1;
              phase_mul <= 1'b0;
              mx <= pfa_pkg::SEL_ACC; my <= pfa_pkg::SEL_ACC;
              state <= S_MUL;
            end else if (op == pfa_pkg::OP_DIV) begin
              pass2 <= 1'b1;
              mx <= pfa_pkg::SEL_A; my <= pfa_pkg::SEL_ACC;
              state <= S_MUL;
            end
          end
        end
        S_GTH: state <= S_DONE;
        // hold the result until the transfer
        S_DONE: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/prime_field_alu_p251m9.sv]
// Top level: field ALU modulo 2^251-9 built from controller and datapath
// Sequence from the accepting edge to out valid: add/sub load, fold, final subtract;
//   mul/square 64 32x32 products, fold, subtract; gt_half and unused ops a compare;
//   power ops 256 squarings plus one multiply per set exponent bit (div one more).
// Throughput: one item at a time; next accepted the cycle after the result transfer.
// Reset: rst synchronous active high returns the controller to idle.
`default_nettype none
module prime_field_alu_p251m9 (
  input wire logic clk,
  input wire logic rst,
  pfa_if.sink      in_ch,
  pfa_if.source    out_ch
);
  pfa_pkg::pfa_cmd_t  cmd;
  pfa_pkg::pfa_stat_t stat;
  logic [250:0] res;
  logic flag_int, ready_int;

  pfa_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .a_in(in_ch.data[259:4]), .b_in(in_ch.data[515:260]),
    .res(res)
  );

  pfa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(ready_int), .op_in(in_ch.data[3:0]),
    .b_raw(in_ch.data[515:260]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .flag_out(flag_int),
    .stat(stat), .cmd(cmd)
  );

  assign in_ch.ready = ready_int;
  assign out_ch.data = {flag_int, res};
endmodule
`default_nettype wire

[hw/rtl/pfa_checker.sv]
// Checker: port-level assertions for the field ALU, bound to the top level
`default_nettype none
module pfa_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [251:0] out_data
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[250:0] < 251'(pfa_pkg::Q))
    else $error("result not reduced");
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind prime_field_alu_p251m9 pfa_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
